>>> sv/gcdf_pkg.sv
// ----------------------------------------------------------------------------
// gcdf_pkg: shared types and constants for the grid distance fill
// Beat structs, operation and status codes, state encoding, defaults.
// ----------------------------------------------------------------------------
package gcdf_pkg;

  localparam int unsigned DistBits       = 24;
  localparam int unsigned DimBits        = 7;
  localparam int unsigned CoordBits      = 6;
  localparam int unsigned GeoBits        = 18;
  localparam int unsigned CfgIdxBits     = 3;
  localparam int unsigned DefMaxTiles    = 4096;
  localparam int unsigned DefQueueDepth  = 8192;

  localparam logic [DistBits-1:0] Sentinel = 24'd2559744;
  localparam logic [DistBits-1:0] DistMax  = {DistBits{1'b1}};

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_RUN   = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTIED  = 2'd1,
    ST_REACHED  = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_WIDTH   = 3'd0,
    REG_HEIGHT  = 3'd1,
    REG_WALK    = 3'd2,
    REG_SWIM    = 3'd3,
    REG_FLY     = 3'd4,
    REG_BLOCKED = 3'd5,
    REG_RANGE   = 3'd6,
    REG_UNUSED  = 3'd7
  } reg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_WAIT,
    S_SEED_RD,
    S_SEED_CHK,
    S_POP,
    S_POP_WAIT,
    S_CUR_WAIT,
    S_NB_RD,
    S_NB_WAIT,
    S_NB_EVAL,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]           operation;
    logic [CoordBits-1:0] tile_x;
    logic [CoordBits-1:0] tile_y;
    logic                 allows_walk;
    logic                 allows_swim;
    logic                 allows_fly;
    logic [DistBits-1:0]  start_distance;
    logic                 use_destination;
  } in_t;

  typedef struct packed {
    logic [DistBits-1:0] distance;
    logic [1:0]          status;
  } out_t;

endpackage

>>> sv/gcdf_ram.sv
// ----------------------------------------------------------------------------
// gcdf_ram: generic single-write, single-read ram
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module gcdf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/grid_cost_distance_fill.sv
// ----------------------------------------------------------------------------
// grid_cost_distance_fill: tile grid distance field with queue relaxation
// Usage:
//   in channel (in_valid_i/in_ready_o, in_data_i) carries one op per beat:
//   write tile, run fill, read tile distance. out channel (out_valid_o/
//   out_ready_i, out_data_o) returns exactly one result beat per op.
//   Configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i while idle.
// Operation:
//   write stores one tile, read returns one tile distance. run scans every
//   tile and queues each at distance zero, then pops queued tiles and relaxes
//   their neighbours on the map in turn. The single read port of the
//   distance ram makes these reads one after another.
//   One op is in flight at a time; in_ready_o is high only when idle.
// Reset: control state, queue pointers and configuration registers return to
//   defaults; tile rams are undefined until written and get no clearing pass.
// Stall: a finished result waits in the output register; the block goes
//   back to idle and takes the next op while it waits, and only holds in
//   its final step if a second result meets a full output register.
// ----------------------------------------------------------------------------
module grid_cost_distance_fill #(
  parameter int unsigned MAX_TILES   = gcdf_pkg::DefMaxTiles,
  parameter int unsigned QUEUE_DEPTH = gcdf_pkg::DefQueueDepth
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  gcdf_pkg::in_t                       in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output gcdf_pkg::out_t                      out_data_o,
  input  logic                                cfg_we_i,
  input  logic [gcdf_pkg::CfgIdxBits-1:0]     cfg_idx_i,
  input  logic [gcdf_pkg::DistBits-1:0]       cfg_data_i
);

  localparam int unsigned IW  = $clog2(MAX_TILES);
  localparam int unsigned QW  = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned GW  = gcdf_pkg::GeoBits;
  localparam int unsigned DW  = gcdf_pkg::DistBits;
  localparam logic [GW-1:0] MaxTilesG   = GW'(MAX_TILES);
  localparam logic [CW-1:0] QueueDepthC = CW'(QUEUE_DEPTH);
  localparam logic [QW-1:0] QueueLastQ  = QW'(QUEUE_DEPTH - 1);

  // configuration registers
  logic [gcdf_pkg::DimBits-1:0] width_q, height_q;
  logic [DW-1:0] walk_q, swim_q, fly_q, blocked_q, range_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= 7'd64;
      height_q  <= 7'd64;
      walk_q    <= 24'd256;
      swim_q    <= 24'd512;
      fly_q     <= 24'd768;
      blocked_q <= gcdf_pkg::Sentinel;
      range_q   <= gcdf_pkg::Sentinel;
    end else if (cfg_we_i) begin
      unique case (gcdf_pkg::reg_e'(cfg_idx_i))
        gcdf_pkg::REG_WIDTH:   width_q   <= cfg_data_i[gcdf_pkg::DimBits-1:0];
        gcdf_pkg::REG_HEIGHT:  height_q  <= cfg_data_i[gcdf_pkg::DimBits-1:0];
        gcdf_pkg::REG_WALK:    walk_q    <= cfg_data_i;
        gcdf_pkg::REG_SWIM:    swim_q    <= cfg_data_i;
        gcdf_pkg::REG_FLY:     fly_q     <= cfg_data_i;
        gcdf_pkg::REG_BLOCKED: blocked_q <= cfg_data_i;
        gcdf_pkg::REG_RANGE:   range_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // geometry
  logic [gcdf_pkg::DimBits-1:0] w_c, h_c;
  logic [GW-1:0] area, tiles, w_g, in_idx;
  logic in_on_map;

  always_comb begin
    w_c = (width_q == '0) ? 7'd1 : ((width_q > 7'd64) ? 7'd64 : width_q);
    h_c = (height_q == '0) ? 7'd1 : ((height_q > 7'd64) ? 7'd64 : height_q);
    w_g = GW'(w_c);
    area = GW'(w_c) * GW'(h_c);
    tiles = (area > MaxTilesG) ? MaxTilesG : area;
    in_idx = GW'(in_data_i.tile_x) + GW'(GW'(in_data_i.tile_y) * w_g);
    in_on_map = (GW'(in_data_i.tile_x) < w_g) && (GW'(in_data_i.tile_y) < GW'(h_c))
                && (in_idx < tiles);
  end

  // control and datapath registers
  gcdf_pkg::state_e state_q, state_d;
  logic [QW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CW-1:0] count_q, count_d;
  logic          ovf_q, ovf_d;
  logic          dest_ok_q, dest_ok_d;
  logic [GW-1:0] dest_q, dest_d;
  logic [GW-1:0] seed_q, seed_d;
  logic [GW-1:0] cur_q, cur_d;
  logic [GW-1:0] nb_q, nb_d;
  logic [1:0]    dir_q, dir_d;
  logic [DW-1:0] cur_dist_q, cur_dist_d;
  logic [DW-1:0] old_q, old_d;
  logic [DW-1:0] cost_q, cost_d;
  logic          ok_q, ok_d;
  logic          rd_hit_q, rd_hit_d;
  gcdf_pkg::out_t res_q, res_d;
  logic          out_valid_q, out_valid_d;
  gcdf_pkg::out_t out_q, out_d;

  // ram ports
  logic          d_we, d_re, c_we, c_re, q_we, q_re;
  logic [IW-1:0] d_waddr, d_raddr, c_raddr, in_addr;
  logic [DW-1:0] d_wdata, d_rdata;
  logic [2:0]    c_rdata;
  logic [QW-1:0] q_raddr;
  logic [IW-1:0] q_wdata, q_rdata;

  gcdf_ram #(.WIDTH(DW), .DEPTH(MAX_TILES)) u_dist_ram (
    .clk_i, .we_i(d_we), .waddr_i(d_waddr), .wdata_i(d_wdata),
    .re_i(d_re), .raddr_i(d_raddr), .rdata_o(d_rdata)
  );

  gcdf_ram #(.WIDTH(3), .DEPTH(MAX_TILES)) u_class_ram (
    .clk_i, .we_i(c_we), .waddr_i(in_addr),
    .wdata_i({in_data_i.allows_fly, in_data_i.allows_swim, in_data_i.allows_walk}),
    .re_i(c_re), .raddr_i(c_raddr), .rdata_o(c_rdata)
  );

  gcdf_ram #(.WIDTH(IW), .DEPTH(QUEUE_DEPTH)) u_queue_ram (
    .clk_i, .we_i(q_we), .waddr_i(tail_q), .wdata_i(q_wdata),
    .re_i(q_re), .raddr_i(q_raddr), .rdata_o(q_rdata)
  );

  logic          slot_free, push, push_ok;
  logic [GW-1:0] push_idx;
  logic [DW:0]   sum;
  logic [DW-1:0] cand;

  assign in_addr   = in_idx[IW-1:0];
  assign slot_free = !out_valid_q || out_ready_i;
  assign push_ok   = count_q < QueueDepthC;

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    tail_d     = tail_q;
    count_d    = count_q;
    ovf_d      = ovf_q;
    dest_ok_d  = dest_ok_q;
    dest_d     = dest_q;
    seed_d     = seed_q;
    cur_d      = cur_q;
    nb_d       = nb_q;
    dir_d      = dir_q;
    cur_dist_d = cur_dist_q;
    old_d      = old_q;
    cost_d     = cost_q;
    ok_d       = ok_q;
    rd_hit_d   = rd_hit_q;
    res_d      = res_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d      = out_q;
    in_ready_o = 1'b0;
    d_we = 1'b0; d_waddr = in_addr; d_wdata = in_data_i.start_distance;
    d_re = 1'b0; d_raddr = in_addr;
    c_we = 1'b0; c_re = 1'b0; c_raddr = nb_q[IW-1:0];
    q_re = 1'b0; q_raddr = head_q;
    push = 1'b0; push_idx = seed_q;
    sum  = {1'b0, cur_dist_q} + {1'b0, cost_q};
    cand = sum[DW] ? gcdf_pkg::DistMax : sum[DW-1:0];

    unique case (state_q)
      gcdf_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          res_d = '{distance: '0, status: gcdf_pkg::ST_OK};
          unique case (gcdf_pkg::op_e'(in_data_i.operation))
            gcdf_pkg::OP_WRITE: begin
              d_we = in_on_map;
              c_we = in_on_map;
              state_d = gcdf_pkg::S_DONE;
            end
            gcdf_pkg::OP_RUN: begin
              head_d = '0; tail_d = '0; count_d = '0; ovf_d = 1'b0;
              dest_ok_d = in_data_i.use_destination && (GW'(in_data_i.tile_x) < w_g);
              dest_d = in_idx;
              seed_d = tiles;
              state_d = gcdf_pkg::S_SEED_RD;
            end
            gcdf_pkg::OP_READ: begin
              d_re = in_on_map;
              rd_hit_d = in_on_map;
              state_d = gcdf_pkg::S_RD_WAIT;
            end
            default: state_d = gcdf_pkg::S_DONE;
          endcase
        end
      end
      gcdf_pkg::S_RD_WAIT: begin
        res_d.distance = rd_hit_q ? d_rdata : '0;
        state_d = gcdf_pkg::S_DONE;
      end
      gcdf_pkg::S_SEED_RD: begin
        if (seed_q == '0) begin
          state_d = gcdf_pkg::S_POP;
        end else begin
          d_re = 1'b1;
          d_raddr = IW'(seed_q - 1'b1);
          seed_d = seed_q - 1'b1;
          state_d = gcdf_pkg::S_SEED_CHK;
        end
      end
      gcdf_pkg::S_SEED_CHK: begin
        push = (d_rdata == '0);
        push_idx = seed_q;
        state_d = gcdf_pkg::S_SEED_RD;
      end
      gcdf_pkg::S_POP: begin
        if (count_q == '0) begin
          res_d.status = ovf_q ? gcdf_pkg::ST_OVERFLOW : gcdf_pkg::ST_EMPTIED;
          state_d = gcdf_pkg::S_DONE;
        end else begin
          q_re = 1'b1;
          head_d = (head_q == QueueLastQ) ? '0 : head_q + 1'b1;
          count_d = count_q - 1'b1;
          state_d = gcdf_pkg::S_POP_WAIT;
        end
      end
      gcdf_pkg::S_POP_WAIT: begin
        cur_d = GW'(q_rdata);
        if (dest_ok_q && (GW'(q_rdata) == dest_q)) begin
          res_d.status = ovf_q ? gcdf_pkg::ST_OVERFLOW : gcdf_pkg::ST_REACHED;
          state_d = gcdf_pkg::S_DONE;
        end else begin
          d_re = 1'b1;
          d_raddr = q_rdata;
          dir_d = 2'd0;
          state_d = gcdf_pkg::S_CUR_WAIT;
        end
      end
      gcdf_pkg::S_CUR_WAIT: begin
        cur_dist_d = d_rdata;
        state_d = gcdf_pkg::S_NB_RD;
      end
      gcdf_pkg::S_NB_RD: begin
        // neighbour order: +width, -width, +1, -1
        ok_d = 1'b0;
        unique case (dir_q)
          2'd0: begin nb_d = cur_q + w_g;  ok_d = (cur_q + w_g) < tiles; end
          2'd1: begin nb_d = cur_q - w_g;  ok_d = cur_q >= w_g;          end
          2'd2: begin nb_d = cur_q + 1'b1; ok_d = (cur_q + 1'b1) < tiles; end
          default: begin nb_d = cur_q - 1'b1; ok_d = cur_q != '0;       end
        endcase
        if (ok_d) begin
          d_re = 1'b1; c_re = 1'b1;
          d_raddr = nb_d[IW-1:0];
          c_raddr = nb_d[IW-1:0];
          state_d = gcdf_pkg::S_NB_WAIT;
        end else begin
          dir_d = dir_q + 1'b1;
          state_d = (dir_q == 2'd3) ? gcdf_pkg::S_POP : gcdf_pkg::S_NB_RD;
        end
      end
      gcdf_pkg::S_NB_WAIT: begin
        old_d = d_rdata;
        ok_d = 1'b1;
        priority if (c_rdata[0]) cost_d = walk_q;
        else if (c_rdata[1]) cost_d = swim_q;
        else if (c_rdata[2]) cost_d = fly_q;
        else if (d_rdata >= gcdf_pkg::Sentinel) cost_d = blocked_q;
        else begin
          cost_d = blocked_q;
          ok_d = 1'b0;
        end
        if (cost_d >= gcdf_pkg::Sentinel) ok_d = 1'b0;
        state_d = gcdf_pkg::S_NB_EVAL;
      end
      gcdf_pkg::S_NB_EVAL: begin
        if (ok_q && (cand < old_q) && (cand < range_q)) begin
          d_we = 1'b1;
          d_waddr = nb_q[IW-1:0];
          d_wdata = cand;
          push = 1'b1;
          push_idx = nb_q;
        end
        dir_d = dir_q + 1'b1;
        state_d = (dir_q == 2'd3) ? gcdf_pkg::S_POP : gcdf_pkg::S_NB_RD;
      end
      gcdf_pkg::S_DONE: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_d = res_q;
          state_d = gcdf_pkg::S_IDLE;
        end
      end
      default: state_d = gcdf_pkg::S_IDLE;
    endcase

    // queue push, dropped on a full queue
    q_we = push && push_ok;
    q_wdata = push_idx[IW-1:0];
    if (push) begin
      if (push_ok) begin
        tail_d = (tail_q == QueueLastQ) ? '0 : tail_q + 1'b1;
        count_d = count_q + 1'b1;
      end else begin
        ovf_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gcdf_pkg::S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dest_ok_q  <= dest_ok_d;
    dest_q     <= dest_d;
    seed_q     <= seed_d;
    cur_q      <= cur_d;
    nb_q       <= nb_d;
    dir_q      <= dir_d;
    cur_dist_q <= cur_dist_d;
    old_q      <= old_d;
    cost_q     <= cost_d;
    ok_q       <= ok_d;
    rd_hit_q   <= rd_hit_d;
    res_q      <= res_d;
    out_q      <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> sv/gcdf_checker.sv
// ----------------------------------------------------------------------------
// gcdf_checker: port-level checks for the grid distance fill
// Watches the handshakes and result beats of the top level.
// ----------------------------------------------------------------------------
module gcdf_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input gcdf_pkg::out_t out_data_o
);

  // a result beat holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat dropped or changed while stalled");

  // one op in flight: accepting a beat closes the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while an op is in flight");

  // a new result only follows work on an op
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result beat without an op");

  // run results carry no distance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != gcdf_pkg::ST_OK) |-> out_data_o.distance == '0)
    else $error("run result with nonzero distance");

endmodule

bind grid_cost_distance_fill gcdf_checker u_gcdf_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i, .out_data_o
);
